// ===== hw/rtl/rcpw_pkg.sv =====
// Shared types and constants for the RC pulse-width capture block.
// Used by the lane, merge and top-level modules; depends on nothing else.
`timescale 1ns / 1ps

package rcpw_pkg;

  // Default sizes of the capture core.
  localparam int unsigned CHANNELS_DEF  = 6;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Fixed field widths of the ports.
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned WIDTH_W = 32;
  localparam int unsigned ANGLE_W = 8;

  // Angle mapping: 180 * (width - 1100) / 800, which reduces to 9 * d / 40.
  localparam int unsigned ANGLE_BASE_US = 1100;
  localparam int unsigned SPAN_MAX_US   = 2000;
  localparam int unsigned SPAN_W        = 11;
  localparam int unsigned SCALED_W      = SPAN_W + 4;
  localparam int unsigned QUOT_IN_W     = SCALED_W - 3;
  localparam int unsigned RECIP_SHIFT   = 15;
  localparam int unsigned RECIP_W       = 13;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 13'd6554;
  localparam int unsigned PROD_W        = QUOT_IN_W + RECIP_W;
  localparam int unsigned QUOT_W        = PROD_W - RECIP_SHIFT;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd255;

  // Per-lane pipeline enables driven from the top level.
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic s2_load;  // first stage moves into the second stage
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/rc_pulse_width_capture_top.sv =====
// RC pulse-width capture: per-channel lanes, two-stage pipeline and merge stage.
// Depends on rcpw_pkg, rcpw_lane and rcpw_merge.
//
// Usage: each input transaction carries the six pin levels and a microsecond
// timestamp. A rising edge on a channel stores the timestamp; a falling edge
// yields one output transaction with channel, width_us, angle and last, where
// last marks the final result of that sample. Samples without a falling edge
// produce nothing. Results of one sample come in ascending channel order.
// The first result of a sample passes the first and second stages, the merge
// stage and the output register before out_valid rises. Throughput: one
// sample per cycle while in_stall is low, one result per cycle at the output
// register while out_stall is low; a sample with many falling edges holds the
// merge stage until all of its results are out, which limits the rate.
// Reset clears the previous levels and every rise time to zero and empties
// the pipeline. When the receiver raises out_stall the output holds, the
// merge and pipeline stages fill, and in_stall rises once no stage is free.
`timescale 1ns / 1ps

module rc_pulse_width_capture_top import rcpw_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [LEVEL_W-1:0] pin_levels,
  input  logic [STAMP_W-1:0] now_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAN_W-1:0]  channel,
  output logic [WIDTH_W-1:0] width_us,
  output logic [ANGLE_W-1:0] angle,
  output logic               last
);

  logic [CHANNELS-1:0]  levels;
  logic [CHANNELS-1:0]  prev_levels;
  logic [TIME_BITS-1:0] now;
  logic [CHANNELS-1:0]  fall;
  logic [CHANNELS-1:0]  s1_mask;
  logic [CHANNELS-1:0]  s2_mask;
  logic                 s1_valid;
  logic                 s2_valid;
  logic                 s1_free;
  logic                 s2_free;
  logic                 accept;
  logic                 merge_take;
  lane_ctrl_t           ctrl;
  logic [WIDTH_W-1:0]   lane_width [CHANNELS];
  logic [ANGLE_W-1:0]   lane_angle [CHANNELS];

  assign levels = CHANNELS'(pin_levels);
  assign now    = TIME_BITS'(now_us);

  // Pipeline advance and input handshake.
  assign s2_free      = ~s2_valid | merge_take;
  assign s1_free      = ~s1_valid | s2_free;
  assign in_stall     = ~s1_free;
  assign accept       = in_valid & s1_free;
  assign ctrl.accept  = accept;
  assign ctrl.s2_load = s1_valid & s2_free;

  // Previous sample levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
    end else if (accept) begin
      prev_levels <= levels;
    end
  end

  // Stage valids; samples without any falling edge are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= accept && (fall != '0);
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mask <= fall;
    end
    if (ctrl.s2_load) begin
      s2_mask <= s1_mask;
    end
  end

  // One lane per channel.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    rcpw_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .level      (levels[g]),
      .prev_level (prev_levels[g]),
      .now        (now),
      .fall       (fall[g]),
      .width_out  (lane_width[g]),
      .angle_out  (lane_angle[g])
    );
  end

  // Merge the lane results into one output transaction per falling edge.
  rcpw_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_mask   (s2_mask),
    .in_width  (lane_width),
    .in_angle  (lane_angle),
    .take      (merge_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .channel   (channel),
    .width_us  (width_us),
    .angle     (angle),
    .last      (last)
  );

endmodule

// ===== hw/rtl/rcpw_lane.sv =====
// One capture lane: edge detection, rise-time register, width and angle pipeline.
// Depends on rcpw_pkg for constants and the lane control struct.
`timescale 1ns / 1ps

module rcpw_lane import rcpw_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctrl_t           ctrl,
  input  logic                 level,
  input  logic                 prev_level,
  input  logic [TIME_BITS-1:0] now,
  output logic                 fall,
  output logic [WIDTH_W-1:0]   width_out,
  output logic [ANGLE_W-1:0]   angle_out
);

  logic                 rising;
  logic [TIME_BITS-1:0] rise_time;
  logic [TIME_BITS-1:0] width1;
  logic [TIME_BITS-1:0] span;
  logic [SPAN_W-1:0]    span_n;
  logic [SCALED_W-1:0]  scaled;
  logic [QUOT_IN_W-1:0] eighth;
  logic [PROD_W-1:0]    prod;
  logic [QUOT_W-1:0]    quot;
  logic [ANGLE_W-1:0]   angle;

  // Edge detection against the previous sample.
  assign rising = level & ~prev_level;
  assign fall   = ~level & prev_level;

  // Rise time is captured on every rising edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_time <= '0;
    end else if (ctrl.accept && rising) begin
      rise_time <= now;
    end
  end

  // First stage: pulse width, modulo the timer range.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      width1 <= now - rise_time;
    end
  end

  // Angle = floor(9 * d / 40): multiply by nine, drop three bits, then
  // divide by five through a reciprocal that is exact over this range.
  always_comb begin
    span   = width1 - TIME_BITS'(ANGLE_BASE_US);
    span_n = span[SPAN_W-1:0];
    scaled = SCALED_W'({span_n, 3'b000}) + SCALED_W'(span_n);
    eighth = scaled[SCALED_W-1:3];
    prod   = PROD_W'(eighth) * PROD_W'(RECIP_FIVE);
    quot   = prod[PROD_W-1:RECIP_SHIFT];
    if (width1 <= TIME_BITS'(ANGLE_BASE_US)) begin
      angle = '0;
    end else if (span > TIME_BITS'(SPAN_MAX_US)) begin
      angle = ANGLE_MAX;
    end else if (quot > QUOT_W'(ANGLE_MAX)) begin
      angle = ANGLE_MAX;
    end else begin
      angle = quot[ANGLE_W-1:0];
    end
  end

  // Second stage: width trimmed to the output field, angle registered.
  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      width_out <= WIDTH_W'(width1);
      angle_out <= angle;
    end
  end

endmodule

// ===== hw/rtl/rcpw_merge.sv =====
// Merge stage: serializes the falling-edge results of one sample in channel order.
// Depends on rcpw_pkg for field widths.
`timescale 1ns / 1ps

module rcpw_merge import rcpw_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [CHANNELS-1:0] in_mask,
  input  logic [WIDTH_W-1:0]  in_width [CHANNELS],
  input  logic [ANGLE_W-1:0]  in_angle [CHANNELS],
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAN_W-1:0]   channel,
  output logic [WIDTH_W-1:0]  width_us,
  output logic [ANGLE_W-1:0]  angle,
  output logic                last
);

  logic [CHANNELS-1:0] mask;
  logic [WIDTH_W-1:0]  width_r [CHANNELS];
  logic [ANGLE_W-1:0]  angle_r [CHANNELS];
  logic [CHANNELS-1:0] pick;
  logic [CHANNELS-1:0] rest;
  logic [CHAN_W-1:0]   pick_idx;
  logic                out_free;
  logic                pop;

  // Lowest pending channel goes out first.
  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick     = '0;
        pick[i]  = 1'b1;
        pick_idx = CHAN_W'(i);
      end
    end
    rest = mask & ~pick;
  end

  assign out_free = ~out_valid | ~out_stall;
  assign pop      = (mask != '0) && out_free;
  assign take     = (mask == '0) || (pop && (rest == '0));

  // Pending set: reload from the pipeline once the current sample drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (take) begin
      mask <= in_valid ? in_mask : '0;
    end else if (pop) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      width_r <= in_width;
      angle_r <= in_angle;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      channel  <= pick_idx;
      width_us <= width_r[pick_idx];
      angle    <= angle_r[pick_idx];
      last     <= (rest == '0);
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for rc_pulse_width_capture_top.
// Drives pin-level samples, predicts pulse widths and angles, and checks each result.
// Depends on rcpw_pkg and the capture top level.
`timescale 1ns / 1ps

module testbench;
  import rcpw_pkg::*;

  localparam int NUM_CH       = LEVEL_W;
  localparam int LIMIT_CYCLES = 300000;
  localparam int TAIL_CYCLES  = 24;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [WIDTH_W-1:0] width;
    logic [ANGLE_W-1:0] ang;
    logic               is_last;
  } pulse_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [LEVEL_W-1:0] pin_levels = '0;
  logic [STAMP_W-1:0] now_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAN_W-1:0]  channel;
  logic [WIDTH_W-1:0] width_us;
  logic [ANGLE_W-1:0] angle;
  logic               last;

  // Predictor state: levels of the last accepted sample and rise stamps.
  logic [LEVEL_W-1:0] seen_levels = '0;
  logic [STAMP_W-1:0] rise_us [NUM_CH];
  pulse_result_t      pending_pulses[$];
  pulse_result_t      want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  rc_pulse_width_capture_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pin_levels (pin_levels),
    .now_us     (now_us),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .channel    (channel),
    .width_us   (width_us),
    .angle      (angle),
    .last       (last)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung pipeline ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Maps a pulse width to the 0..255 angle scale (180 per 800 us), truncated and saturated.
  function automatic logic [ANGLE_W-1:0] servo_angle(input logic [WIDTH_W-1:0] w);
    logic [31:0] span;
    logic [31:0] scaled;
    if (w <= WIDTH_W'(ANGLE_BASE_US)) return '0;
    span = w - WIDTH_W'(ANGLE_BASE_US);
    if (span > SPAN_MAX_US) return ANGLE_MAX;
    scaled = (span * 32'd180) / 32'd800;
    return (scaled > 32'd255) ? ANGLE_MAX : scaled[ANGLE_W-1:0];
  endfunction

  // Updates rise stamps and queues one expected result per falling channel.
  task automatic predict_pulses(input logic [LEVEL_W-1:0] lv, input logic [STAMP_W-1:0] ts);
    logic [LEVEL_W-1:0] moved;
    logic [LEVEL_W-1:0] falls;
    int top;
    pulse_result_t r;
    moved = lv ^ seen_levels;
    falls = moved & ~lv;
    top = -1;
    for (int k = 0; k < NUM_CH; k++) begin
      if (falls[k]) top = k;
    end
    for (int k = 0; k < NUM_CH; k++) begin
      if (moved[k] && lv[k]) begin
        rise_us[k] = ts;
      end else if (moved[k]) begin
        r.chan    = CHAN_W'(k);
        r.width   = ts - rise_us[k];
        r.ang     = servo_angle(r.width);
        r.is_last = (k == top);
        pending_pulses.push_back(r);
      end
    end
    seen_levels = lv;
  endtask

  // Sends one sample transaction, idling first at the phase's rate.
  // Valid stays high after acceptance so back-to-back samples need no toggle.
  task automatic send_sample(input logic [LEVEL_W-1:0] lv, input logic [STAMP_W-1:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pin_levels <= lv;
    now_us     <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pulses(lv, ts);
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pulses.size() != 0);
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        $error("unexpected result: channel %0d width_us %0d", channel, width_us);
        error_count++;
      end else begin
        want = pending_pulses.pop_front();
        if (channel !== want.chan) begin
          $error("channel: expected %0d, got %0d", want.chan, channel);
          error_count++;
        end
        if (width_us !== want.width) begin
          $error("width_us: expected %0d, got %0d", want.width, width_us);
          error_count++;
        end
        if (angle !== want.ang) begin
          $error("angle: expected %0d, got %0d", want.ang, angle);
          error_count++;
        end
        if (last !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, last);
          error_count++;
        end
      end
    end
  end

  // Picks a pulse length: mostly in the servo band, sometimes far outside it.
  function automatic logic [STAMP_W-1:0] pick_pulse_width();
    case ($urandom_range(9))
      0:       return $urandom_range(0, 1100);
      1:       return $urandom_range(2200, 6000);
      default: return $urandom_range(1000, 2000);
    endcase
  endfunction

  // Angle boundaries, timestamp wrap, simultaneous edges and all six falling at once.
  task automatic test_directed_edges();
    send_sample(6'h00, 32'd0);
    send_sample(6'h3F, 32'hFFFF_FF00);
    send_sample(6'h00, 32'h0000_0100);
    send_sample(6'h01, 32'd1000);
    send_sample(6'h02, 32'd2100);
    send_sample(6'h04, 32'd3201);
    send_sample(6'h08, 32'd5101);
    send_sample(6'h10, 32'd7334);
    send_sample(6'h20, 32'd9572);
    send_sample(6'h00, 32'd12672);
    send_sample(6'h15, 32'd20000);
    send_sample(6'h2A, 32'd21500);
    send_sample(6'h00, 32'hFFFF_FFFF);
    send_sample(6'h3F, 32'hFFFF_FFFF);
    send_sample(6'h3F, 32'd0);
    send_sample(6'h00, 32'd1099);
    send_sample(6'h01, 32'd777);
    send_sample(6'h00, 32'd777);
    send_sample(6'h3F, 32'hAAAA_AAAA);
    send_sample(6'h00, 32'h5555_5555);
  endtask

  // Bursts of all-six falls under stall, a pause until the pipeline is empty, then random-level bursts.
  task automatic test_burst_drain();
    logic [STAMP_W-1:0] ts;
    ts = $urandom();
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    for (int n = 0; n < 5; n++) begin
      ts = ts + $urandom_range(1, 3000);
      send_sample(6'h3F, ts);
      ts = ts + $urandom_range(1, 3000);
      send_sample(6'h00, ts);
    end
    wait_for_drain();
    for (int n = 0; n < 5; n++) begin
      ts = ts + $urandom_range(1, 3000);
      send_sample(LEVEL_W'($urandom_range(0, 63)), ts);
      ts = ts + $urandom_range(1, 3000);
      send_sample(6'h00, ts);
    end
  endtask

  // Well-formed servo traffic: each channel rises, holds for a chosen width, falls.
  // A few glitches flip single pins to break up the pattern.
  task automatic test_servo_pulses(input int n_items, input int idle_pct, input int stall_pct);
    logic [STAMP_W-1:0] t;
    logic [LEVEL_W-1:0] lv;
    logic [LEVEL_W-1:0] nxt;
    logic [STAMP_W-1:0] rise_at [NUM_CH];
    logic [STAMP_W-1:0] hold [NUM_CH];
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    t  = $urandom();
    lv = seen_levels;
    for (int k = 0; k < NUM_CH; k++) begin
      rise_at[k] = t;
      hold[k]    = pick_pulse_width();
    end
    for (int n = 0; n < n_items; n++) begin
      t   = t + $urandom_range(1, 250);
      nxt = lv;
      for (int k = 0; k < NUM_CH; k++) begin
        if (lv[k] && (t - rise_at[k]) >= hold[k]) nxt[k] = 1'b0;
        else if (!lv[k] && $urandom_range(99) < 15) nxt[k] = 1'b1;
      end
      if ($urandom_range(99) < 5) nxt[$urandom_range(NUM_CH - 1)] ^= 1'b1;
      for (int k = 0; k < NUM_CH; k++) begin
        if (nxt[k] && !lv[k]) begin
          rise_at[k] = t;
          hold[k]    = pick_pulse_width();
        end
      end
      lv = nxt;
      send_sample(lv, t);
    end
  endtask

  // Unstructured samples: any levels, any timestamp.
  task automatic test_random_noise(input int n_items);
    send_idle_pct  = 12;
    recv_stall_pct = 46;
    for (int n = 0; n < n_items; n++) begin
      send_sample(LEVEL_W'($urandom_range(0, 63)), $urandom());
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_CH; k++) rise_us[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_burst_drain();
    test_servo_pulses(85, 0, 0);
    test_servo_pulses(85, 46, 0);
    test_servo_pulses(85, 0, 46);
    test_servo_pulses(85, 12, 12);
    test_random_noise(50);

    // Let any stray result show up after the last expected one.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
